/* sv/nsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_pkg
// Shared types and constants of the note strummer and its note-off queue.
// ----------------------------------------------------------------------------
package nsq_pkg;

  // default sizes
  localparam int unsigned LIST_DEPTH_DEF = 16;
  localparam int unsigned RING_DEPTH_DEF = 32;

  // field widths
  localparam int unsigned PITCH_W = 7;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned TIME_W  = 16;
  localparam int unsigned ACT_W   = 3;
  localparam int unsigned LIDX_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // register reset values
  localparam logic [VEL_W-1:0]  VEL_RST  = 7'd64;
  localparam logic [TIME_W-1:0] DUR_RST  = 16'd1000;
  localparam logic [TIME_W-1:0] RATE_RST = 16'd2;

  // action codes
  localparam logic [ACT_W-1:0] ACT_TICK  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PLAY  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STRUM = 3'd3;
  localparam logic [ACT_W-1:0] ACT_MUTE  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 3'd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VELOCITY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HARP     = 3'd4;

  // strum modes
  localparam logic [1:0] MODE_UP   = 2'd0;
  localparam logic [1:0] MODE_DOWN = 2'd1;
  localparam logic [1:0] MODE_ALT  = 2'd2;

  // one queue entry: remaining ticks until its note-off
  typedef struct packed {
    logic              occ;
    logic              live;
    logic [PITCH_W-1:0] pitch;
    logic [TIME_W-1:0]  rem;
  } entry_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_DEC,
    OP_POP,
    OP_INS,
    OP_PURGE
  } cell_op_e;

  // command broadcast to every cell
  typedef struct packed {
    cell_op_e           op;
    logic [PITCH_W-1:0] pitch;
    logic [TIME_W-1:0]  key;
  } cell_cmd_t;

endpackage

/* sv/nsq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_cell
// One slot of the sorted note-off queue. Shifts toward the head on a pop,
// toward the tail on an insert, and takes part in the first-match purge chain.
// ----------------------------------------------------------------------------
module nsq_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nsq_pkg::cell_cmd_t cmd_i,
  input  nsq_pkg::entry_t   left_i,
  input  logic              left_keep_i,
  input  nsq_pkg::entry_t   right_i,
  input  logic              found_i,
  output nsq_pkg::entry_t   entry_o,
  output logic              keep_o,
  output logic              found_o
);

  nsq_pkg::entry_t entry_q, entry_d, new_entry;
  logic match;

  assign match   = entry_q.occ && entry_q.live && (entry_q.pitch == cmd_i.pitch);
  assign keep_o  = entry_q.occ && (entry_q.rem < cmd_i.key);
  assign found_o = found_i | match;
  assign entry_o = entry_q;

  always_comb begin
    new_entry       = '0;
    new_entry.occ   = 1'b1;
    new_entry.live  = 1'b1;
    new_entry.pitch = cmd_i.pitch;
    new_entry.rem   = cmd_i.key;
  end

  // next slot content
  always_comb begin
    entry_d = entry_q;
    unique case (cmd_i.op)
      nsq_pkg::OP_DEC: begin
        if (entry_q.occ) entry_d.rem = entry_q.rem - 1'b1;
      end
      nsq_pkg::OP_POP: entry_d = right_i;
      nsq_pkg::OP_INS: begin
        if (!keep_o) entry_d = left_keep_i ? new_entry : left_i;
      end
      nsq_pkg::OP_PURGE: begin
        if (match && !found_i) entry_d.live = 1'b0;
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

/* sv/note_strummer_with_noteoff_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_strummer_with_noteoff_queue
// Note player and strummer with a time-sorted queue of pending note-offs.
// ----------------------------------------------------------------------------
// The note-off queue is a row of RING_DEPTH-1 cells kept sorted by remaining
// ticks; an insert, a pop from the head, a purge of one pitch and a tick
// decrement are each one command broadcast across the whole row. An item is
// handled by a sequencer one at a time: a tick decrements the row and then
// retires the due entries from the head, a played note cuts the previous note
// (unless in harp mode), purges its own pitch, sends the note-on and inserts
// its note-off, retiring the head of a full queue first, a mute purges one
// pitch, a strum purges, sounds and queues each list note, a flush pops
// every queued entry, and each ends in a closing state; the sequencer stalls
// while the output register and its one-word hold stage are both occupied.
// No clearing pass is needed after reset.
module note_strummer_with_noteoff_queue #(
  parameter int unsigned LIST_DEPTH = nsq_pkg::LIST_DEPTH_DEF,
  parameter int unsigned RING_DEPTH = nsq_pkg::RING_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [nsq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nsq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // action[2:0], pitch[9:3], list_index[13:10]
  input  logic        s_axis_tlast,   // list_last
  // output words
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // note_pitch[6:0], note_velocity[13:7]
  output logic        m_axis_tlast    // last_of_run
);

  localparam int unsigned NCELL = RING_DEPTH - 1;
  localparam int unsigned CW    = $clog2(RING_DEPTH);
  localparam int unsigned LW    = $clog2(LIST_DEPTH + 1);
  localparam int unsigned PW    = LW + 1;
  localparam int unsigned IW    = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic signed [PW-1:0] POS_ONE = PW'(1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_TDEC, ST_TRET, ST_STRUM, ST_PPURGE, ST_NPURGE,
    ST_NON, ST_NINS, ST_MUTE, ST_FLUSH, ST_FIN
  } state_e;

  // configuration registers
  logic [nsq_pkg::VEL_W-1:0]  vel_q;
  logic [nsq_pkg::TIME_W-1:0] dur_q, rate_q;
  logic [1:0]                 mode_q;
  logic                       harp_q;

  // sequencer state
  state_e                      state_q;
  logic [nsq_pkg::PITCH_W-1:0] np_q, cur_q;
  logic                        in_strum_q;
  logic [nsq_pkg::PITCH_W-1:0] chord_q [LIST_DEPTH];
  logic [LW-1:0]               len_q;
  logic signed [PW-1:0]        pos_q;
  logic                        dir_q;
  logic [nsq_pkg::TIME_W-1:0]  cd_q;
  logic                        pend_q;
  logic [CW-1:0]               cnt_q;

  // output staging
  logic                        hold_v_q, out_v_q, out_last_q;
  logic [nsq_pkg::PITCH_W-1:0] hold_p_q, out_p_q;
  logic [nsq_pkg::VEL_W-1:0]   hold_vel_q, out_vel_q;

  // input fields
  logic [nsq_pkg::ACT_W-1:0]   in_act;
  logic [nsq_pkg::PITCH_W-1:0] in_pitch;
  logic [nsq_pkg::LIDX_W-1:0]  in_idx;

  assign in_act   = s_axis_tdata[2:0];
  assign in_pitch = s_axis_tdata[9:3];
  assign in_idx   = s_axis_tdata[13:10];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {2'b00, out_vel_q, out_p_q};
  assign m_axis_tlast  = out_last_q;

  logic out_free, can_emit;
  assign out_free = !out_v_q || m_axis_tready;
  assign can_emit = !hold_v_q || out_free;

  // cell row
  nsq_pkg::cell_cmd_t cmd;
  nsq_pkg::entry_t    ent   [NCELL];
  nsq_pkg::entry_t    left  [NCELL];
  nsq_pkg::entry_t    right [NCELL];
  logic               keep  [NCELL];
  logic               lkeep [NCELL];
  logic               fnd   [NCELL];
  logic               fin   [NCELL];

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    if (g == 0) begin : g_first
      assign left[g]  = '0;
      assign lkeep[g] = 1'b1;
      assign fin[g]   = 1'b0;
    end else begin : g_mid
      assign left[g]  = ent[g-1];
      assign lkeep[g] = keep[g-1];
      assign fin[g]   = fnd[g-1];
    end
    if (g == NCELL - 1) begin : g_lastc
      assign right[g] = '0;
    end else begin : g_notlast
      assign right[g] = ent[g+1];
    end
    nsq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .left_i      (left[g]),
      .left_keep_i (lkeep[g]),
      .right_i     (right[g]),
      .found_i     (fin[g]),
      .entry_o     (ent[g]),
      .keep_o      (keep[g]),
      .found_o     (fnd[g])
    );
  end

  nsq_pkg::entry_t head;
  logic            full, found;
  assign head  = ent[0];
  assign found = fnd[NCELL-1];
  assign full  = (cnt_q == CW'(NCELL));

  // strum position checks
  logic signed [PW-1:0] len_s;
  logic                 pos_ok;
  assign len_s  = $signed({1'b0, len_q});
  assign pos_ok = (pos_q >= 0) && (pos_q < len_s);

  // cell command and emitted word
  logic                        emit_req;
  logic [nsq_pkg::PITCH_W-1:0] emit_p;
  logic [nsq_pkg::VEL_W-1:0]   emit_vel;
  logic                        pop_now;

  always_comb begin
    cmd.op    = nsq_pkg::OP_NOP;
    cmd.pitch = np_q;
    cmd.key   = dur_q;
    emit_req  = 1'b0;
    emit_p    = np_q;
    emit_vel  = '0;
    pop_now   = 1'b0;
    unique case (state_q)
      ST_TDEC: cmd.op = nsq_pkg::OP_DEC;
      ST_TRET, ST_FLUSH: begin
        if (head.occ && can_emit && (state_q == ST_FLUSH || head.rem == '0)) begin
          cmd.op   = nsq_pkg::OP_POP;
          pop_now  = 1'b1;
          emit_req = head.live;
          emit_p   = head.pitch;
        end
      end
      ST_PPURGE, ST_NPURGE, ST_MUTE: begin
        if (state_q == ST_PPURGE) cmd.pitch = cur_q;
        emit_p = cmd.pitch;
        if (can_emit) begin
          cmd.op   = nsq_pkg::OP_PURGE;
          emit_req = found;
        end
      end
      ST_NON: begin
        emit_req = can_emit;
        emit_vel = vel_q;
      end
      ST_NINS: begin
        if (full) begin
          if (can_emit) begin
            cmd.op   = nsq_pkg::OP_POP;
            pop_now  = 1'b1;
            emit_req = head.live;
            emit_p   = head.pitch;
          end
        end else begin
          cmd.op = nsq_pkg::OP_INS;
        end
      end
      default: cmd.op = nsq_pkg::OP_NOP;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vel_q  <= nsq_pkg::VEL_RST;
      dur_q  <= nsq_pkg::DUR_RST;
      rate_q <= nsq_pkg::RATE_RST;
      mode_q <= nsq_pkg::MODE_UP;
      harp_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        nsq_pkg::REG_VELOCITY: vel_q <= cfg_data_i[nsq_pkg::VEL_W-1:0];
        nsq_pkg::REG_DURATION: dur_q <= (cfg_data_i == '0) ? 16'd1 : cfg_data_i;
        nsq_pkg::REG_RATE:     rate_q <= cfg_data_i;
        nsq_pkg::REG_MODE:     mode_q <= cfg_data_i[1:0];
        nsq_pkg::REG_HARP:     harp_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // sequencer
  logic [nsq_pkg::TIME_W-1:0] cd_next;
  assign cd_next = (cd_q != '0) ? cd_q - 1'b1 : cd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      np_q       <= '0;
      cur_q      <= '0;
      in_strum_q <= 1'b0;
      for (int k = 0; k < LIST_DEPTH; k++) chord_q[k] <= '0;
      len_q      <= '0;
      pos_q      <= '0;
      dir_q      <= 1'b0;
      cd_q       <= '0;
      pend_q     <= 1'b0;
      cnt_q      <= '0;
    end else begin
      // queue fill count
      if (pop_now) cnt_q <= cnt_q - 1'b1;
      else if (cmd.op == nsq_pkg::OP_INS) cnt_q <= cnt_q + 1'b1;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            np_q       <= in_pitch;
            in_strum_q <= 1'b0;
            case (in_act)
              nsq_pkg::ACT_TICK: state_q <= ST_TDEC;
              nsq_pkg::ACT_PLAY: state_q <= harp_q ? ST_NPURGE : ST_PPURGE;
              nsq_pkg::ACT_LOAD: begin
                if (32'(in_idx) < LIST_DEPTH) chord_q[IW'(in_idx)] <= in_pitch;
                if (32'(in_idx) < LIST_DEPTH && s_axis_tlast) begin
                  for (int k = 0; k < LIST_DEPTH; k++) begin
                    if (k > int'(in_idx)) chord_q[k] <= '0;
                  end
                  len_q  <= LW'(32'(in_idx) + 32'd1);
                  pend_q <= 1'b0;
                  cd_q   <= '0;
                  if (mode_q == nsq_pkg::MODE_DOWN) begin
                    pos_q <= PW'(32'(in_idx));
                    dir_q <= 1'b1;
                  end else if (mode_q == nsq_pkg::MODE_ALT) begin
                    pos_q <= dir_q ? '0 : PW'(32'(in_idx));
                    dir_q <= !dir_q;
                  end else begin
                    pos_q <= '0;
                    dir_q <= 1'b0;
                  end
                  state_q <= ST_STRUM;
                end else begin
                  state_q <= ST_FIN;
                end
              end
              nsq_pkg::ACT_STRUM: begin
                pend_q <= 1'b0;
                cd_q   <= '0;
                if (mode_q == nsq_pkg::MODE_DOWN) begin
                  pos_q <= len_s - POS_ONE;
                  dir_q <= 1'b1;
                end else if (mode_q == nsq_pkg::MODE_ALT) begin
                  pos_q <= dir_q ? '0 : len_s - POS_ONE;
                  dir_q <= !dir_q;
                end else begin
                  pos_q <= '0;
                  dir_q <= 1'b0;
                end
                state_q <= ST_STRUM;
              end
              nsq_pkg::ACT_MUTE: state_q <= ST_MUTE;
              nsq_pkg::ACT_FLUSH: begin
                cur_q   <= '0;
                state_q <= ST_FLUSH;
              end
              default: state_q <= ST_FIN;
            endcase
          end
        end
        ST_TDEC: state_q <= ST_TRET;
        ST_TRET: begin
          // after the due entries, run the strum countdown
          if (!(head.occ && head.rem == '0)) begin
            if (pend_q) cd_q <= cd_next;
            if (pend_q && cd_next == '0) begin
              pend_q  <= 1'b0;
              state_q <= ST_STRUM;
            end else begin
              state_q <= ST_FIN;
            end
          end
        end
        ST_STRUM: begin
          if (len_q != '0 && pos_ok) begin
            np_q       <= chord_q[pos_q[IW-1:0]];
            pos_q      <= dir_q ? pos_q - POS_ONE : pos_q + POS_ONE;
            in_strum_q <= 1'b1;
            state_q    <= ST_NPURGE;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_PPURGE: if (can_emit) state_q <= ST_NPURGE;
        ST_NPURGE: if (can_emit) state_q <= ST_NON;
        ST_NON:    if (can_emit) state_q <= ST_NINS;
        ST_NINS: begin
          if (!full) begin
            cur_q <= np_q;
            if (in_strum_q && rate_q == '0) begin
              state_q <= ST_STRUM;
            end else begin
              state_q <= ST_FIN;
            end
            if (in_strum_q && rate_q != '0 && pos_ok) begin
              pend_q <= 1'b1;
              cd_q   <= rate_q;
            end
          end
        end
        ST_MUTE:  if (can_emit) state_q <= ST_FIN;
        ST_FLUSH: if (!head.occ) state_q <= ST_FIN;
        ST_FIN:   if (!hold_v_q || out_free) state_q <= ST_IDLE;
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

  // hold stage and output register: the held word learns it is last at the end
  logic push_out, fin_out;
  assign push_out = emit_req && hold_v_q;
  assign fin_out  = !emit_req && (state_q == ST_FIN) && hold_v_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      hold_p_q   <= '0;
      hold_vel_q <= '0;
      out_p_q    <= '0;
      out_vel_q  <= '0;
    end else begin
      if (push_out || fin_out) begin
        out_v_q    <= 1'b1;
        out_p_q    <= hold_p_q;
        out_vel_q  <= hold_vel_q;
        out_last_q <= fin_out;
      end else if (out_v_q && m_axis_tready) begin
        out_v_q <= 1'b0;
      end
      if (emit_req) begin
        hold_v_q   <= 1'b1;
        hold_p_q   <= emit_p;
        hold_vel_q <= emit_vel;
      end else if (fin_out) begin
        hold_v_q <= 1'b0;
      end
    end
  end

endmodule
